/* hdl/tga_rle_pixel_decoder_top_assert.svh */
// Assertion macros for the run-length pixel decoder checker.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef TGA_RLE_PIXEL_DECODER_TOP_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, masked while in reset
`define TGA_RLE_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while in reset
`define TGA_RLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tga_rle_pkg.sv */
package tga_rle_pkg;

	localparam int BYTE_W     = 8;
	localparam int COLUMN_W   = 12;
	localparam int ROW_W      = 16;
	localparam int REPEAT_W   = 8;
	localparam int WIDTH_W    = 13;
	localparam int HEIGHT_W   = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// Header byte layout
	localparam int          RUN_FLAG_BIT = 7;
	localparam logic [7:0]  RUN_FLAG     = 8'h80;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
	localparam logic [12:0] LINE_WIDTH_RESET = 13'd4096;

	// Register map of the configuration channel
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_IS_32BIT = 8'd0,
		REG_LINE_WIDTH     = 8'd1,
		REG_IMAGE_HEIGHT   = 8'd2,
		REG_FLIP_ROWS      = 8'd3
	} cfg_reg_t;

	// Byte slot within a stored pixel
	typedef enum logic [1:0] {
		SLOT_BLUE  = 2'd0,
		SLOT_GREEN = 2'd1,
		SLOT_RED   = 2'd2,
		SLOT_ALPHA = 2'd3
	} pix_slot_t;

endpackage

/* hdl/tga_rle_channels.sv */
// Compressed byte stream channel
interface tga_rle_byte_if;
	logic                           valid;
	logic                           ready;
	logic [tga_rle_pkg::BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// Decoded pixel span channel
interface tga_rle_span_if;
	logic                             valid;
	logic                             ready;
	logic [tga_rle_pkg::BYTE_W-1:0]   red;
	logic [tga_rle_pkg::BYTE_W-1:0]   green;
	logic [tga_rle_pkg::BYTE_W-1:0]   blue;
	logic [tga_rle_pkg::BYTE_W-1:0]   alpha;
	logic [tga_rle_pkg::COLUMN_W-1:0] column;
	logic [tga_rle_pkg::ROW_W-1:0]    row;
	logic [tga_rle_pkg::REPEAT_W-1:0] repeat_res;
	logic                             line_end;
	logic                             image_end;

	modport source (output valid, output red, output green, output blue, output alpha,
		output column, output row, output repeat_res, output line_end, output image_end,
		input ready);
	modport sink (input valid, input red, input green, input blue, input alpha,
		input column, input row, input repeat_res, input line_end, input image_end,
		output ready);
endinterface

// Register write channel
interface tga_rle_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [tga_rle_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [tga_rle_pkg::CFG_DATA_W-1:0] wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

/* hdl/tga_rle_pixel_decoder_top.sv */
// Run-length coded Targa pixel decoder.
// stream: one compressed byte per beat (headers and stored BGR/BGRA bytes).
// span:   one beat per completed pixel that lands inside the line, giving the
//         RGBA value, column, row, repeat count and line/image end flags.
//         Header bytes, non-final pixel bytes and pixels past the line end
//         give no beat.
// cfg:    register writes (depth, line width, height, row flip), always ready;
//         write only while the decoder is idle.
// Path: a byte is registered in the byte stage on acceptance, and its span is
// registered in the result register once that stage advances.
// Throughput: one byte per cycle while no span is stalled; the two registers
// work as a pipeline and the packet counters update in a single pass per byte.
// Stall: while a span waits on span.ready the byte register holds, and
// stream.ready drops only once that register is full as well.
// Reset: arst_n clears the pipeline and decoder state and loads the register
// defaults (32-bit pixels, width 4096, height 1, no flip).
module tga_rle_pixel_decoder_top #(
	parameter int MAX_LINE_PIXELS = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tga_rle_byte_if.sink          stream,
	tga_rle_span_if.source        span,
	tga_rle_cfg_if.sink           cfg
);

	localparam int CW = $clog2(MAX_LINE_PIXELS + 1);
	localparam int RW = (CW > tga_rle_pkg::REPEAT_W) ? CW : tga_rle_pkg::REPEAT_W;

	// Configuration registers
	logic                               is32_q;
	logic [tga_rle_pkg::WIDTH_W-1:0]    line_width_q;
	logic [tga_rle_pkg::HEIGHT_W-1:0]   height_q;
	logic                               flip_q;

	// Input stage
	logic                               valid_s1;
	logic [tga_rle_pkg::BYTE_W-1:0]     byte_s1;

	// Decoder state
	logic                               expect_header_q;
	logic                               run_q;
	logic [tga_rle_pkg::REPEAT_W-1:0]   pixels_left_q;
	logic [1:0]                         slot_q;
	logic [23:0]                        held_q;
	logic [CW-1:0]                      col_q;
	logic [tga_rle_pkg::ROW_W-1:0]      row_q;

	// Result register
	logic                               out_valid_q;
	logic [tga_rle_pkg::BYTE_W-1:0]     red_q, green_q, blue_q, alpha_q;
	logic [tga_rle_pkg::COLUMN_W-1:0]   column_q;
	logic [tga_rle_pkg::ROW_W-1:0]      row_out_q;
	logic [tga_rle_pkg::REPEAT_W-1:0]   repeat_q;
	logic                               line_end_q;
	logic                               image_end_q;

	// Combinational
	logic [CW-1:0]                      eff_w;
	logic [tga_rle_pkg::HEIGHT_W-1:0]   eff_h;
	logic [1:0]                         last_slot;
	logic                               advance;
	logic                               line_full;
	logic                               pixel_done;
	logic                               emit;
	logic [RW-1:0]                      rep_raw;
	logic [RW-1:0]                      remain;
	logic [RW-1:0]                      rep_clip;
	logic [CW-1:0]                      col_next;
	logic                               lend;
	logic                               row_last;
	logic [tga_rle_pkg::ROW_W-1:0]      row_out;
	logic [tga_rle_pkg::BYTE_W-1:0]     red_c, alpha_c;
	logic [tga_rle_pkg::REPEAT_W-1:0]   left_dec;

	// Accept register writes at any time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is32_q       <= 1'b1;
			line_width_q <= tga_rle_pkg::LINE_WIDTH_RESET;
			height_q     <= 16'd1;
			flip_q       <= 1'b0;
		end else if (cfg.valid) begin
			unique case (tga_rle_pkg::cfg_reg_t'(cfg.reg_index))
				tga_rle_pkg::REG_PIXEL_IS_32BIT: is32_q <= cfg.wr_data[0];
				tga_rle_pkg::REG_LINE_WIDTH: line_width_q <= cfg.wr_data[tga_rle_pkg::WIDTH_W-1:0];
				tga_rle_pkg::REG_IMAGE_HEIGHT: height_q <= cfg.wr_data;
				tga_rle_pkg::REG_FLIP_ROWS: flip_q <= cfg.wr_data[0];
				default: ;
			endcase
		end
	end

	// Clamp line width and height into their working ranges
	always_comb begin
		if (line_width_q == '0) begin
			eff_w = CW'(1);
		end else if (32'(line_width_q) > 32'(MAX_LINE_PIXELS)) begin
			eff_w = CW'(MAX_LINE_PIXELS);
		end else begin
			eff_w = CW'(line_width_q);
		end
		eff_h = (height_q == '0) ? 16'd1 : height_q;
	end

	assign last_slot = is32_q ? tga_rle_pkg::SLOT_ALPHA : tga_rle_pkg::SLOT_RED;

	// Advance the byte stage when the result register can take its outcome
	assign advance      = valid_s1 && (!out_valid_q || span.ready);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.data_byte;
		end
	end

	// Span arithmetic
	assign line_full  = col_q >= eff_w;
	assign pixel_done = !expect_header_q && !(slot_q < last_slot);
	assign emit       = pixel_done && !line_full;
	assign rep_raw    = run_q ? RW'(pixels_left_q) : RW'(1);
	assign remain     = RW'(eff_w) - RW'(col_q);
	assign rep_clip   = (rep_raw > remain) ? remain : rep_raw;
	assign col_next   = col_q + CW'(rep_clip);
	assign lend       = col_next >= eff_w;
	assign row_last   = ({1'b0, row_q} + 17'd1) >= {1'b0, eff_h};
	assign row_out    = flip_q ? (eff_h - 16'd1 - row_q) : row_q;
	assign red_c      = is32_q ? held_q[23:16] : byte_s1;
	assign alpha_c    = is32_q ? byte_s1 : tga_rle_pkg::ALPHA_OPAQUE;
	assign left_dec   = pixels_left_q - 8'd1;

	// Step the packet parser on each byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q <= 1'b1;
			run_q           <= 1'b0;
			pixels_left_q   <= '0;
			slot_q          <= tga_rle_pkg::SLOT_BLUE;
			held_q          <= '0;
			col_q           <= '0;
			row_q           <= '0;
		end else if (advance) begin
			if (expect_header_q) begin
				run_q           <= byte_s1[tga_rle_pkg::RUN_FLAG_BIT];
				pixels_left_q   <= {1'b0, byte_s1[6:0] & ~tga_rle_pkg::RUN_FLAG[6:0]} + 8'd1;
				slot_q          <= tga_rle_pkg::SLOT_BLUE;
				expect_header_q <= 1'b0;
				if (line_full) begin
					col_q <= '0;
				end
			end else if (!pixel_done) begin
				case (slot_q)
					tga_rle_pkg::SLOT_BLUE:  held_q[7:0]   <= byte_s1;
					tga_rle_pkg::SLOT_GREEN: held_q[15:8]  <= byte_s1;
					default:                 held_q[23:16] <= byte_s1;
				endcase
				slot_q <= slot_q + 2'd1;
			end else begin
				slot_q <= tga_rle_pkg::SLOT_BLUE;
				if (run_q) begin
					pixels_left_q   <= '0;
					expect_header_q <= 1'b1;
				end else begin
					pixels_left_q <= left_dec;
					if (left_dec == '0) begin
						expect_header_q <= 1'b1;
					end
				end
				if (emit) begin
					col_q <= col_next;
					if (lend) begin
						row_q <= row_last ? '0 : row_q + 16'd1;
					end
				end
			end
		end
	end

	// Hold the span until taken, load a new one when the stage advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (span.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			red_q       <= red_c;
			green_q     <= held_q[15:8];
			blue_q      <= held_q[7:0];
			alpha_q     <= alpha_c;
			column_q    <= tga_rle_pkg::COLUMN_W'(col_q);
			row_out_q   <= row_out;
			repeat_q    <= tga_rle_pkg::REPEAT_W'(rep_clip);
			line_end_q  <= lend;
			image_end_q <= lend && row_last;
		end
	end

	assign span.valid      = out_valid_q;
	assign span.red        = red_q;
	assign span.green      = green_q;
	assign span.blue       = blue_q;
	assign span.alpha      = alpha_q;
	assign span.column     = column_q;
	assign span.row        = row_out_q;
	assign span.repeat_res = repeat_q;
	assign span.line_end   = line_end_q;
	assign span.image_end  = image_end_q;

endmodule

/* hdl/tga_rle_checker.sv */
`include "tga_rle_pixel_decoder_top_assert.svh"

module tga_rle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        span_valid,
	input logic        span_ready,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic [7:0]  alpha,
	input logic [11:0] column,
	input logic [15:0] row,
	input logic [7:0]  repeat_res,
	input logic        line_end,
	input logic        image_end,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	logic after_line_end_q;

	// Track whether the last span closed a line; a register write voids it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_line_end_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			after_line_end_q <= 1'b0;
		end else if (span_valid && span_ready) begin
			after_line_end_q <= line_end;
		end
	end

	`TGA_RLE_ASSERT(a_repeat_range, span_valid, (repeat_res != 8'd0) && (repeat_res <= 8'd128), "span repeat out of range")
	`TGA_RLE_ASSERT(a_image_end_on_line_end, span_valid && image_end, line_end, "image end without line end")
	`TGA_RLE_ASSERT(a_new_line_at_col0, span_valid && after_line_end_q, column == 12'd0, "line does not start at column zero")
	`TGA_RLE_ASSERT_NEXT(a_span_hold, span_valid && !span_ready, span_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(alpha) && $stable(column) && $stable(row) && $stable(repeat_res) && $stable(line_end) && $stable(image_end), "stalled span beat changed")

endmodule

bind tga_rle_pixel_decoder_top tga_rle_checker u_tga_rle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.span_valid (span.valid),
	.span_ready (span.ready),
	.red        (span.red),
	.green      (span.green),
	.blue       (span.blue),
	.alpha      (span.alpha),
	.column     (span.column),
	.row        (span.row),
	.repeat_res (span.repeat_res),
	.line_end   (span.line_end),
	.image_end  (span.image_end),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_PIXELS    = 4096;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_BYTES  = 340;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [tga_rle_pkg::BYTE_W-1:0]   red;
		logic [tga_rle_pkg::BYTE_W-1:0]   green;
		logic [tga_rle_pkg::BYTE_W-1:0]   blue;
		logic [tga_rle_pkg::BYTE_W-1:0]   alpha;
		logic [tga_rle_pkg::COLUMN_W-1:0] column;
		logic [tga_rle_pkg::ROW_W-1:0]    row;
		logic [tga_rle_pkg::REPEAT_W-1:0] repeat_res;
		logic                             line_end;
		logic                             image_end;
	} span_beat_t;

	logic clk;
	logic arst_n;

	tga_rle_byte_if stream ();
	tga_rle_span_if span ();
	tga_rle_cfg_if  cfg ();

	tga_rle_pixel_decoder_top #(.MAX_LINE_PIXELS(MAX_PIXELS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.span   (span),
		.cfg    (cfg)
	);

	// Decoder image: registers and packet state
	logic                             dec_is_32bit;
	logic [tga_rle_pkg::WIDTH_W-1:0]  dec_line_width;
	logic [tga_rle_pkg::HEIGHT_W-1:0] dec_height;
	logic                             dec_flip;
	logic                             dec_want_header;
	logic                             dec_run;
	int                               dec_pixels_left;
	int                               dec_slot;
	logic [23:0]                      dec_held;
	int                               dec_column;
	int                               dec_row;

	logic [tga_rle_pkg::BYTE_W-1:0] compressed_bytes [$];
	span_beat_t                     pending_spans [$];

	logic gen_is_32bit;
	int   bytes_pushed;
	int   bytes_taken;
	int   spans_seen;
	int   line_ends_seen;
	int   image_ends_seen;
	int   cfg_writes;
	int   errors;
	int   cycles;
	int   burst_left;
	int   gap_left;
	int   stall_cycle;

	// Advance the decoder image by one compressed byte; return 1 when a span results
	function automatic bit decode_byte(input logic [tga_rle_pkg::BYTE_W-1:0] b,
			output span_beat_t s);
		int w;
		int h;
		int last_slot;
		int rep;
		int row;
		logic [tga_rle_pkg::BYTE_W-1:0] red;
		logic [tga_rle_pkg::BYTE_W-1:0] alpha;
		s = '0;
		w = int'(dec_line_width);
		if (w == 0) w = 1;
		if (w > MAX_PIXELS) w = MAX_PIXELS;
		h = (dec_height == 0) ? 1 : int'(dec_height);
		last_slot = dec_is_32bit ? int'(tga_rle_pkg::SLOT_ALPHA) : int'(tga_rle_pkg::SLOT_RED);

		// Header opens a packet; a full line restarts at column zero
		if (dec_want_header) begin
			dec_run = b[tga_rle_pkg::RUN_FLAG_BIT];
			dec_pixels_left = int'(b[6:0]) + 1;
			dec_slot = int'(tga_rle_pkg::SLOT_BLUE);
			dec_want_header = 1'b0;
			if (dec_column >= w) dec_column = 0;
			return 1'b0;
		end

		// Hold the leading bytes of the pixel
		if (dec_slot < last_slot) begin
			dec_held[8*dec_slot +: 8] = b;
			dec_slot = dec_slot + 1;
			return 1'b0;
		end

		// Final byte completes the pixel
		dec_slot = int'(tga_rle_pkg::SLOT_BLUE);
		red   = dec_is_32bit ? dec_held[23:16] : b;
		alpha = dec_is_32bit ? b : tga_rle_pkg::ALPHA_OPAQUE;
		if (dec_run) begin
			rep = dec_pixels_left;
			dec_pixels_left = 0;
			dec_want_header = 1'b1;
		end else begin
			rep = 1;
			dec_pixels_left = (dec_pixels_left - 1) & 'hFF;
			if (dec_pixels_left == 0) dec_want_header = 1'b1;
		end

		// Drop pixels past the line end
		if (dec_column >= w) return 1'b0;

		if (rep > w - dec_column) rep = w - dec_column;
		row = dec_flip ? ((h - 1 - dec_row) & 'hFFFF) : dec_row;
		s.red        = red;
		s.green      = dec_held[15:8];
		s.blue       = dec_held[7:0];
		s.alpha      = alpha;
		s.column     = dec_column[tga_rle_pkg::COLUMN_W-1:0];
		s.row        = row[tga_rle_pkg::ROW_W-1:0];
		s.repeat_res = rep[tga_rle_pkg::REPEAT_W-1:0];
		dec_column   = dec_column + rep;
		s.line_end   = (dec_column >= w);
		if (s.line_end) begin
			if (dec_row + 1 >= h) begin
				dec_row = 0;
				s.image_end = 1'b1;
			end else begin
				dec_row = (dec_row + 1) & 'hFFFF;
			end
		end
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Byte driver: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream.valid     <= 1'b0;
			stream.data_byte <= '0;
			burst_left       <= 0;
			gap_left         <= 0;
		end else if (!stream.valid || stream.ready) begin
			if (gap_left > 0) begin
				gap_left     <= gap_left - 1;
				stream.valid <= 1'b0;
			end else if (compressed_bytes.size() > 0) begin
				stream.valid     <= 1'b1;
				stream.data_byte <= compressed_bytes.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				stream.valid <= 1'b0;
			end
		end
	end

	// Span receiver: rotate through free-running, light, periodic and heavy stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span.ready  <= 1'b0;
			stall_cycle <= 0;
		end else begin
			stall_cycle <= stall_cycle + 1;
			case (stall_cycle[8:7])
				2'd0: span.ready <= 1'b1;
				2'd1: span.ready <= ($urandom_range(0, 9) < 7);
				2'd2: span.ready <= (stall_cycle[2:0] == 3'd0);
				default: span.ready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	// Monitor: track register writes, predict spans, compare span beats
	always @(posedge clk or negedge arst_n) begin
		span_beat_t predicted;
		span_beat_t want;
		if (!arst_n) begin
			dec_is_32bit    = 1'b1;
			dec_line_width  = tga_rle_pkg::LINE_WIDTH_RESET;
			dec_height      = 16'd1;
			dec_flip        = 1'b0;
			dec_want_header = 1'b1;
			dec_run         = 1'b0;
			dec_pixels_left = 0;
			dec_slot        = int'(tga_rle_pkg::SLOT_BLUE);
			dec_held        = '0;
			dec_column      = 0;
			dec_row         = 0;
			pending_spans.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					tga_rle_pkg::REG_PIXEL_IS_32BIT: dec_is_32bit = cfg.wr_data[0];
					tga_rle_pkg::REG_LINE_WIDTH:
						dec_line_width = cfg.wr_data[tga_rle_pkg::WIDTH_W-1:0];
					tga_rle_pkg::REG_IMAGE_HEIGHT:
						dec_height = cfg.wr_data[tga_rle_pkg::HEIGHT_W-1:0];
					tga_rle_pkg::REG_FLIP_ROWS:      dec_flip = cfg.wr_data[0];
					default: ;
				endcase
			end
			if (stream.valid && stream.ready) begin
				bytes_taken++;
				if (decode_byte(stream.data_byte, predicted)) pending_spans.push_back(predicted);
			end
			if (span.valid && span.ready) begin
				spans_seen++;
				if (span.line_end === 1'b1) line_ends_seen++;
				if (span.image_end === 1'b1) image_ends_seen++;
				if (pending_spans.size() == 0) begin
					$error("span beat with no span expected");
					errors++;
				end else begin
					want = pending_spans.pop_front();
					check_field("red", 32'(want.red), 32'(span.red));
					check_field("green", 32'(want.green), 32'(span.green));
					check_field("blue", 32'(want.blue), 32'(span.blue));
					check_field("alpha", 32'(want.alpha), 32'(span.alpha));
					check_field("column", 32'(want.column), 32'(span.column));
					check_field("row", 32'(want.row), 32'(span.row));
					check_field("repeat_res", 32'(want.repeat_res), 32'(span.repeat_res));
					check_field("line_end", 32'(want.line_end), 32'(span.line_end));
					check_field("image_end", 32'(want.image_end), 32'(span.image_end));
				end
			end
		end
	end

	function automatic logic [tga_rle_pkg::BYTE_W-1:0] rand_byte();
		return tga_rle_pkg::BYTE_W'($urandom_range(0, 255));
	endfunction

	task automatic push_byte(input logic [tga_rle_pkg::BYTE_W-1:0] b);
		compressed_bytes.push_back(b);
		bytes_pushed++;
	endtask

	task automatic push_pixels(input int n);
		repeat (n * (gen_is_32bit ? 4 : 3)) push_byte(rand_byte());
	endtask

	task automatic push_packet(input bit run, input int count);
		logic [tga_rle_pkg::BYTE_W-1:0] header;
		header = 8'(count - 1);
		if (run) header = header | tga_rle_pkg::RUN_FLAG;
		push_byte(header);
		push_pixels(run ? 1 : count);
	endtask

	// Mostly short packets, now and then a long one
	function automatic int pick_count(input bit run);
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return $urandom_range(1, 4);
		if (r < 9) return $urandom_range(5, 16);
		return run ? $urandom_range(17, 128) : $urandom_range(17, 40);
	endfunction

	// Hold off until every byte is taken and every span has come, then let it settle
	task automatic wait_idle();
		do @(negedge clk);
		while (compressed_bytes.size() != 0 || stream.valid || pending_spans.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input tga_rle_pkg::cfg_reg_t idx, input int value);
		@(posedge clk);
		cfg.valid     <= 1'b1;
		cfg.reg_index <= idx;
		cfg.wr_data   <= tga_rle_pkg::CFG_DATA_W'(value);
		do @(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == tga_rle_pkg::REG_PIXEL_IS_32BIT) gen_is_32bit = value[0];
		cfg_writes++;
	endtask

	task automatic configure(input bit is_32bit, input int width, input int height,
			input bit flip);
		wait_idle();
		write_reg(tga_rle_pkg::REG_PIXEL_IS_32BIT, int'(is_32bit));
		write_reg(tga_rle_pkg::REG_LINE_WIDTH, width);
		write_reg(tga_rle_pkg::REG_IMAGE_HEIGHT, height);
		write_reg(tga_rle_pkg::REG_FLIP_ROWS, int'(flip));
	endtask

	// Finish whatever packet the decoder is in, so the next byte is a header
	task automatic realign();
		int last_slot;
		int left;
		last_slot = gen_is_32bit ? int'(tga_rle_pkg::SLOT_ALPHA) : int'(tga_rle_pkg::SLOT_RED);
		left = 0;
		if (!dec_want_header) begin
			left = (dec_slot >= last_slot) ? 1 : last_slot + 1 - dec_slot;
			if (!dec_run) left += (dec_pixels_left - 1) * (last_slot + 1);
		end
		repeat (left) push_byte(rand_byte());
	endtask

	task automatic random_settings();
		int width;
		int height;
		case ($urandom_range(0, 9))
			0: width = 0;
			1: width = MAX_PIXELS;
			2: width = $urandom_range(MAX_PIXELS + 1, 8191);
			3: width = $urandom_range(21, 300);
			default: width = $urandom_range(1, 20);
		endcase
		case ($urandom_range(0, 7))
			0: height = 0;
			1: height = 65535;
			2: height = $urandom_range(0, 65535);
			default: height = $urandom_range(1, 5);
		endcase
		configure(1'($urandom_range(0, 1)), width, height, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int random_start;
		arst_n           = 1'b0;
		stream.valid     = 1'b0;
		stream.data_byte = '0;
		span.ready       = 1'b0;
		cfg.valid        = 1'b0;
		cfg.reg_index    = tga_rle_pkg::REG_PIXEL_IS_32BIT;
		cfg.wr_data      = '0;
		gen_is_32bit     = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset settings: longest run, all-ones and all-zero literal pixels
		push_byte(tga_rle_pkg::RUN_FLAG | 8'h7F);
		push_byte(8'hA5);
		push_byte(8'h5A);
		push_byte(8'hC3);
		push_byte(8'h3C);
		push_byte(8'h01);
		repeat (4) push_byte(8'hFF);
		repeat (4) push_byte(8'h00);

		// 24-bit, narrow flipped image: clipped run, literals, image end
		configure(1'b0, 3, 2, 1'b1);
		push_byte(tga_rle_pkg::RUN_FLAG | 8'h05);
		push_byte(8'h11);
		push_byte(8'h22);
		push_byte(8'h33);
		push_byte(8'h01);
		push_byte(8'h44);
		push_byte(8'h55);
		push_byte(8'h66);
		push_byte(8'h77);
		push_byte(8'h88);
		push_byte(8'h99);
		push_byte(tga_rle_pkg::RUN_FLAG | 8'h01);
		repeat (3) push_byte(8'hFF);

		// Literal that overruns a full line
		configure(1'b0, 2, 3, 1'b0);
		push_packet(1'b0, 5);
		push_packet(1'b1, 1);

		// Depth switched from 32 to 24 bits partway through a pixel
		configure(1'b1, 8, 3, 1'b0);
		push_byte(8'h01);
		push_pixels(0);
		push_byte(rand_byte());
		push_byte(rand_byte());
		wait_idle();
		write_reg(tga_rle_pkg::REG_PIXEL_IS_32BIT, 0);
		realign();

		// Depth switched from 24 to 32 bits partway through a pixel
		push_byte(tga_rle_pkg::RUN_FLAG);
		push_byte(rand_byte());
		wait_idle();
		write_reg(tga_rle_pkg::REG_PIXEL_IS_32BIT, 1);
		realign();

		// Width lowered below the current column inside a literal
		configure(1'b1, 10, 4, 1'b0);
		push_byte(8'h07);
		push_pixels(5);
		wait_idle();
		write_reg(tga_rle_pkg::REG_LINE_WIDTH, 3);
		realign();
		push_packet(1'b1, 3);

		// Height lowered below the current row, with flip
		configure(1'b0, 2, 8, 1'b0);
		repeat (5) push_packet(1'b1, 2);
		wait_idle();
		write_reg(tga_rle_pkg::REG_IMAGE_HEIGHT, 2);
		write_reg(tga_rle_pkg::REG_FLIP_ROWS, 1);
		push_packet(1'b1, 1);
		push_packet(1'b1, 1);

		// Degenerate and oversized sizes
		configure(1'b1, 0, 0, 1'b1);
		push_packet(1'b1, 3);
		push_packet(1'b0, 2);
		configure(1'b0, 8191, 65535, 1'b1);
		push_packet(1'b1, 128);
		push_packet(1'b0, 3);
		wait_idle();

		// Random segments: well-formed packets, then at times a broken tail
		random_start = bytes_pushed;
		while (bytes_pushed - random_start < RANDOM_BYTES) begin
			if ($urandom_range(0, 2) == 0) random_settings();
			realign();
			repeat ($urandom_range(4, 14)) begin
				bit run;
				run = 1'($urandom_range(0, 1));
				push_packet(run, pick_count(run));
			end
			case ($urandom_range(0, 3))
				0: begin
					push_byte(rand_byte());
					repeat ($urandom_range(0, 6)) push_byte(rand_byte());
				end
				1: repeat ($urandom_range(1, 3)) push_byte(rand_byte());
				default: ;
			endcase
			wait_idle();
		end

		wait_idle();
		$display("Decoded %0d stream beats into %0d spans (%0d line ends, %0d image ends)",
			bytes_taken, spans_seen, line_ends_seen, image_ends_seen);
		$display("%0d register writes across both depths, flip, degenerate and oversized sizes",
			cfg_writes);
		if (errors == 0 && pending_spans.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/tga_rle_pkg.sv
hdl/tga_rle_channels.sv
hdl/tga_rle_pixel_decoder_top.sv
hdl/tga_rle_checker.sv
dv/testbench.sv
